[sv/itbb_pkg.sv]
package itbb_pkg;

  localparam int TEMP_W = 16;
  localparam int VAL_W  = 10;
  localparam int SEG_W  = 8;
  localparam int DIG_W  = 4;

  // register indexes, byte address = 4 * index
  localparam logic [2:0] REG_CHANGE_BAND = 3'd0;
  localparam logic [2:0] REG_OFF_BAND    = 3'd1;
  localparam logic [2:0] REG_TEMP_OFFSET = 3'd2;
  localparam logic [2:0] REG_CONV_GAIN   = 3'd3;
  localparam logic [2:0] REG_CONV_BASE   = 3'd4;

  localparam logic [3:0]  RST_CHANGE_BAND = 4'd2;
  localparam logic [7:0]  RST_OFF_BAND    = 8'd30;
  localparam logic [9:0]  RST_TEMP_OFFSET = 10'd245;
  localparam logic [15:0] RST_CONV_GAIN   = 16'd11000;
  localparam logic [15:0] RST_CONV_BASE   = 16'd11253;

  localparam logic [SEG_W-1:0] MARK_BIT     = 8'h20;
  localparam logic [SEG_W-1:0] SEG_FOURTH   = 8'h0F;
  localparam logic [SEG_W-1:0] SEG_OFF_PAT  = 8'h8B;
  localparam logic [SEG_W-1:0] SEG_BLANK    = 8'h00;
  localparam logic [SEG_W-1:0] SEG_ZERO     = 8'hD7;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef struct packed {
    logic [DIG_W-1:0] hund;
    logic [DIG_W-1:0] tens;
    logic [DIG_W-1:0] ones;
    logic [VAL_W-1:0] value;
  } bcd_res_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [DIG_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0: s = 8'hD7;
      4'd1: s = 8'h14;
      4'd2: s = 8'hCD;
      4'd3: s = 8'h5D;
      4'd4: s = 8'h1E;
      4'd5: s = 8'h5B;
      4'd6: s = 8'hDB;
      4'd7: s = 8'h15;
      4'd8: s = 8'hDF;
      4'd9: s = 8'h5F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

[sv/itbb_in_if.sv]
interface itbb_in_if #(parameter int SAMPLE_BITS = 10) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] knob_sample;
  logic [SAMPLE_BITS-1:0] sensor_sample;

  modport source (output valid, knob_sample, sensor_sample, input ready);
  modport sink   (input valid, knob_sample, sensor_sample, output ready);
endinterface

[sv/itbb_out_if.sv]
interface itbb_out_if import itbb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             heater_on;
  logic             show_setpoint;
  logic             off_shown;
  logic [VAL_W-1:0] shown_value;
  logic [SEG_W-1:0] seg_first;
  logic [SEG_W-1:0] seg_second;
  logic [SEG_W-1:0] seg_third;
  logic [SEG_W-1:0] seg_fourth;

  modport source (output valid, heater_on, show_setpoint, off_shown, shown_value,
                  seg_first, seg_second, seg_third, seg_fourth, input ready);
  modport sink   (input valid, heater_on, show_setpoint, off_shown, shown_value,
                  seg_first, seg_second, seg_third, seg_fourth, output ready);
endinterface

[sv/itbb_div.sv]
// Restoring divider, one quotient bit per cycle, dividend MSB first.
module itbb_div import itbb_pkg::*; #(
  parameter int PW = 26
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PW-1:0]     dividend,
  input  logic [TEMP_W-1:0] divisor,
  output unit_stat_t        stat,
  output logic [PW-1:0]     quotient
);

  localparam int CNT_W = $clog2(PW + 1);

  logic [PW-1:0]     quo_r, quo_nxt;
  logic [TEMP_W-1:0] rem_r, rem_nxt;
  logic [TEMP_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [TEMP_W:0]   trial;
  logic              ge;

  assign trial = {rem_r, quo_r[PW-1]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // zero divisor: every trial passes, giving all ones
      rem_nxt = ge ? TEMP_W'(trial - {1'b0, dsr_r}) : trial[TEMP_W-1:0];
      quo_nxt = {quo_r[PW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(PW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

[sv/itbb_bcd.sv]
// Bit-serial binary to three decimal digits, thousands dropped.
// Keeps a binary copy mod 1000 next to the BCD digits.
module itbb_bcd import itbb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TEMP_W-1:0] value,
  output unit_stat_t        stat,
  output bcd_res_t          res
);

  localparam int CNT_W = $clog2(TEMP_W + 1);
  localparam logic [VAL_W:0] Mod = 11'd1000;

  logic [TEMP_W-1:0] src_r, src_nxt;
  logic [DIG_W-1:0]  h_r, h_nxt, t_r, t_nxt, o_r, o_nxt;
  logic [VAL_W-1:0]  bin_r, bin_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIG_W-1:0]  h_adj, t_adj, o_adj;
  logic [VAL_W:0]    bin2;
  logic              bit_in;

  function automatic logic [DIG_W-1:0] adj3(input logic [DIG_W-1:0] d);
    return (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

  assign bit_in = src_r[TEMP_W-1];
  assign h_adj  = adj3(h_r);
  assign t_adj  = adj3(t_r);
  assign o_adj  = adj3(o_r);
  assign bin2   = {bin_r, bit_in};

  always_comb begin
    src_nxt  = src_r;
    h_nxt    = h_r;
    t_nxt    = t_r;
    o_nxt    = o_r;
    bin_nxt  = bin_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      src_nxt  = value;
      h_nxt    = '0;
      t_nxt    = '0;
      o_nxt    = '0;
      bin_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      src_nxt = {src_r[TEMP_W-2:0], 1'b0};
      h_nxt   = {h_adj[DIG_W-2:0], t_adj[DIG_W-1]};
      t_nxt   = {t_adj[DIG_W-2:0], o_adj[DIG_W-1]};
      o_nxt   = {o_adj[DIG_W-2:0], bit_in};
      bin_nxt = (bin2 >= Mod) ? VAL_W'(bin2 - Mod) : bin2[VAL_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(TEMP_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    src_r <= src_nxt;
    h_r   <= h_nxt;
    t_r   <= t_nxt;
    o_r   <= o_nxt;
    bin_r <= bin_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign res.hund  = h_r;
  assign res.tens  = t_r;
  assign res.ones  = o_r;
  assign res.value = bin_r;

endmodule

[sv/iron_temperature_bang_bang_controller_top.sv]
// channel   | dir | beat
// in_chan   | in  | knob_sample, sensor_sample
// out_chan  | out | heater_on, show_setpoint, off_shown, shown_value, seg_first..seg_fourth
// apb       | in  | psel/penable/pwrite/paddr/pwdata, prdata, pready tied high
//
// The beat rate is set by the serial divider, which works one cycle per bit of the
// 16+SAMPLE_BITS bit product. Digit conversion runs alongside it. A zero knob beat
// skips both units and goes straight to the finish state.
// Reset is synchronous, active low; registers come back to their listed values.
// A result held on out_chan stalls only the final load; the next beat is taken
// as soon as the previous result sits in the output register.
module iron_temperature_bang_bang_controller_top import itbb_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  itbb_in_if.sink       in_chan,
  itbb_out_if.source    out_chan,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int SB = SAMPLE_BITS;
  localparam int PW = TEMP_W + SB;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [3:0]  change_band_r;
  logic [7:0]  off_band_r;
  logic [9:0]  temp_offset_r;
  logic [15:0] conv_gain_r;
  logic [15:0] conv_base_r;

  logic [1:0]        state_r, state_nxt;
  logic [SB-1:0]     setpoint_r, setpoint_nxt;
  logic [TEMP_W-1:0] iron_temp_r, iron_temp_nxt;
  logic              heat_mark_r, heat_mark_nxt;
  logic              cool_mark_r, cool_mark_nxt;
  logic              heater_r, heater_nxt;
  logic [SB-1:0]     cand_r;
  logic              moved_r;
  logic              off_r;

  logic              out_valid_r, out_valid_nxt;
  logic              o_heater_r, o_show_r, o_off_r;
  logic [VAL_W-1:0]  o_value_r;
  logic [SEG_W-1:0]  o_seg1_r, o_seg2_r, o_seg3_r, o_seg4_r;

  logic              accept;
  logic              load_out;
  logic [SB-1:0]     cand;
  logic [SB-1:0]     diff;
  logic              moved;
  logic              knob_zero;
  logic [TEMP_W-1:0] bcd_src;
  logic [PW-1:0]     product;
  logic [TEMP_W-1:0] divisor;
  logic [PW-1:0]     quotient;
  unit_stat_t        div_stat;
  unit_stat_t        bcd_stat;
  bcd_res_t          bcd_res;
  logic [SB-1:0]     sp_new;
  logic [TEMP_W-1:0] new_temp;
  logic [TEMP_W-1:0] hi_limit;
  logic              cfg_wen;
  logic [2:0]        reg_idx;

  // ---------------- configuration
  assign pready  = 1'b1;
  assign cfg_wen = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      change_band_r <= RST_CHANGE_BAND;
      off_band_r    <= RST_OFF_BAND;
      temp_offset_r <= RST_TEMP_OFFSET;
      conv_gain_r   <= RST_CONV_GAIN;
      conv_base_r   <= RST_CONV_BASE;
    end else if (cfg_wen) begin
      case (reg_idx)
        REG_CHANGE_BAND: change_band_r <= pwdata[3:0];
        REG_OFF_BAND:    off_band_r    <= pwdata[7:0];
        REG_TEMP_OFFSET: temp_offset_r <= pwdata[9:0];
        REG_CONV_GAIN:   conv_gain_r   <= pwdata[15:0];
        REG_CONV_BASE:   conv_base_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CHANGE_BAND: prdata = 32'(change_band_r);
      REG_OFF_BAND:    prdata = 32'(off_band_r);
      REG_TEMP_OFFSET: prdata = 32'(temp_offset_r);
      REG_CONV_GAIN:   prdata = 32'(conv_gain_r);
      REG_CONV_BASE:   prdata = 32'(conv_base_r);
      default:         prdata = '0;
    endcase
  end

  // ---------------- accept side
  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign knob_zero     = (in_chan.knob_sample == '0);

  assign cand  = {1'b0, in_chan.knob_sample[SB-1:1]} + SB'(2);
  assign diff  = (cand > setpoint_r) ? cand - setpoint_r : setpoint_r - cand;
  assign moved = diff > SB'(change_band_r);

  // wrapped negatives show as zero
  assign bcd_src = moved ? TEMP_W'(cand) : (iron_temp_r[TEMP_W-1] ? '0 : iron_temp_r);
  assign product = PW'(conv_gain_r) * PW'(in_chan.sensor_sample);
  assign divisor = conv_base_r - TEMP_W'(in_chan.sensor_sample);

  always_ff @(posedge clk) begin
    if (accept) begin
      cand_r  <= cand;
      moved_r <= moved;
      off_r   <= knob_zero;
    end
  end

  itbb_div #(.PW(PW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && !knob_zero),
    .dividend (product),
    .divisor  (divisor),
    .stat     (div_stat),
    .quotient (quotient)
  );

  itbb_bcd u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept && !knob_zero),
    .value (bcd_src),
    .stat  (bcd_stat),
    .res   (bcd_res)
  );

  // ---------------- finish: state update and result load
  assign load_out = (state_r == ST_FIN) && (!out_valid_r || out_chan.ready);
  assign sp_new   = moved_r ? cand_r : setpoint_r;
  assign new_temp = quotient[TEMP_W-1:0] - TEMP_W'(temp_offset_r);
  assign hi_limit = TEMP_W'(sp_new) + TEMP_W'(off_band_r);

  always_comb begin
    state_nxt     = state_r;
    setpoint_nxt  = setpoint_r;
    iron_temp_nxt = iron_temp_r;
    heat_mark_nxt = heat_mark_r;
    cool_mark_nxt = cool_mark_r;
    heater_nxt    = heater_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = knob_zero ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (load_out) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (!off_r) begin
            setpoint_nxt  = sp_new;
            iron_temp_nxt = new_temp;
            if (new_temp < TEMP_W'(sp_new)) begin
              heater_nxt    = 1'b1;
              heat_mark_nxt = 1'b1;
              cool_mark_nxt = 1'b0;
            end else if (new_temp > hi_limit) begin
              heater_nxt    = 1'b0;
              heat_mark_nxt = 1'b0;
              cool_mark_nxt = 1'b1;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      setpoint_r  <= '0;
      iron_temp_r <= '0;
      heat_mark_r <= 1'b0;
      cool_mark_r <= 1'b0;
      heater_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      setpoint_r  <= setpoint_nxt;
      iron_temp_r <= iron_temp_nxt;
      heat_mark_r <= heat_mark_nxt;
      cool_mark_r <= cool_mark_nxt;
      heater_r    <= heater_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // marks on the display are the ones before this update
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (off_r) begin
        o_heater_r <= heater_r;
        o_show_r   <= 1'b0;
        o_off_r    <= 1'b1;
        o_value_r  <= '0;
        o_seg1_r   <= SEG_BLANK;
        o_seg2_r   <= SEG_ZERO;
        o_seg3_r   <= SEG_OFF_PAT;
        o_seg4_r   <= SEG_OFF_PAT;
      end else begin
        o_heater_r <= heater_nxt;
        o_show_r   <= moved_r;
        o_off_r    <= 1'b0;
        o_value_r  <= bcd_res.value;
        o_seg1_r   <= seg_of(bcd_res.hund);
        o_seg2_r   <= seg_of(bcd_res.tens) | (heat_mark_r ? MARK_BIT : SEG_BLANK);
        o_seg3_r   <= seg_of(bcd_res.ones) | (cool_mark_r ? MARK_BIT : SEG_BLANK);
        o_seg4_r   <= SEG_FOURTH;
      end
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.heater_on     = o_heater_r;
  assign out_chan.show_setpoint = o_show_r;
  assign out_chan.off_shown     = o_off_r;
  assign out_chan.shown_value   = o_value_r;
  assign out_chan.seg_first     = o_seg1_r;
  assign out_chan.seg_second    = o_seg2_r;
  assign out_chan.seg_third     = o_seg3_r;
  assign out_chan.seg_fourth    = o_seg4_r;

  // ---------------- checks
  a_bcd_before_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !off_r) |-> !bcd_stat.busy && !div_stat.busy)
    else $error("digit or divide unit still busy at finish");

  a_marks_track_heater: assert property (@(posedge clk) disable iff (!rst_n)
    (heater_r == heat_mark_r) && !(heat_mark_r && cool_mark_r))
    else $error("heater and marks disagree");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> $past(state_r == ST_FIN))
    else $error("result loaded outside finish");

  a_setpoint_at_fin: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(setpoint_r)) |-> $past(state_r == ST_FIN && !off_r))
    else $error("setpoint changed outside finish");

endmodule

[bench/tb_iron_temperature_bang_bang_controller_top.sv]
`timescale 1ns / 100ps

module tb_iron_temperature_bang_bang_controller_top import itbb_pkg::*; ();

  localparam int SAMPLE_BITS = 10;
  localparam int SETTLE_CYCLES = 40;
  localparam int ITEMS_PER_SETTING = 300;
  localparam int NUM_SETTINGS = 6;
  // digit patterns 0..9, digit d at bits [8*d +: 8]
  localparam logic [79:0] DIGIT_SEGS = {8'h5F, 8'hDF, 8'h15, 8'hDB, 8'h5B,
                                        8'h1E, 8'h5D, 8'hCD, 8'h14, 8'hD7};

  typedef struct {
    logic [SAMPLE_BITS-1:0] knob;
    logic [SAMPLE_BITS-1:0] sens;
    bit                     drain_first;
  } sample_t;

  typedef struct {
    logic             heater_on;
    logic             show_setpoint;
    logic             off_shown;
    logic [VAL_W-1:0] shown_value;
    logic [SEG_W-1:0] seg_first;
    logic [SEG_W-1:0] seg_second;
    logic [SEG_W-1:0] seg_third;
    logic [SEG_W-1:0] seg_fourth;
  } display_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  itbb_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
  itbb_out_if out_if ();

  iron_temperature_bang_bang_controller_top #(.SAMPLE_BITS(SAMPLE_BITS)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // controller shadow: registers and state
  logic [3:0]  band_q;
  logic [7:0]  off_band_q;
  logic [9:0]  offset_q;
  logic [15:0] gain_q;
  logic [15:0] base_q;
  logic [9:0]  setpoint_q;
  logic [15:0] temp_q;
  logic        heat_mark_q;
  logic        cool_mark_q;
  logic        heater_q;

  sample_t  sample_queue[$];
  display_t due_displays[$];
  int       items_queued;
  int       in_acc_cnt;
  int       in_sent_cnt;
  int       err_count;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       knob_run;
  int       sens_run;
  int       n_results;
  int       n_off;
  int       n_moved;
  int       n_heat;
  int       n_below_zero;
  int       n_settings;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic display_t predict_display(input logic [SAMPLE_BITS-1:0] knob,
                                               input logic [SAMPLE_BITS-1:0] sens);
    display_t    r;
    logic [9:0]  cand;
    int unsigned diff;
    int unsigned shown;
    int unsigned divisor;
    int unsigned quot;
    int unsigned upper;
    logic        moved;
    r.heater_on     = heater_q;
    r.show_setpoint = 1'b0;
    r.off_shown     = 1'b1;
    r.shown_value   = '0;
    r.seg_first     = SEG_BLANK;
    r.seg_second    = SEG_ZERO;
    r.seg_third     = SEG_OFF_PAT;
    r.seg_fourth    = SEG_OFF_PAT;
    if (knob == '0) begin
      n_off++;
      return r;
    end
    cand  = knob / 2 + 2;
    diff  = (cand > setpoint_q) ? cand - setpoint_q : setpoint_q - cand;
    moved = diff > band_q;
    if (moved) begin
      shown = 32'(cand);
      n_moved++;
    end else if (temp_q[15]) begin
      shown = 0;
      n_below_zero++;
    end else begin
      shown = 32'(temp_q);
    end
    shown = shown % 1000;
    r.show_setpoint = moved;
    r.off_shown     = 1'b0;
    r.shown_value   = VAL_W'(shown);
    r.seg_first     = DIGIT_SEGS[8 * ((shown / 100) % 10) +: 8];
    r.seg_second    = DIGIT_SEGS[8 * ((shown / 10) % 10) +: 8] |
                      (heat_mark_q ? MARK_BIT : 8'h00);
    r.seg_third     = DIGIT_SEGS[8 * (shown % 10) +: 8] | (cool_mark_q ? MARK_BIT : 8'h00);
    r.seg_fourth    = SEG_FOURTH;
    if (moved) setpoint_q = cand;
    divisor = (int'(base_q) - int'(sens)) & 32'hFFFF;
    if (divisor == 0) quot = 32'hFFFF_FFFF;
    else quot = (int'(gain_q) * int'(sens)) / divisor;
    temp_q = 16'(quot - offset_q);
    upper  = (int'(setpoint_q) + int'(off_band_q)) & 32'hFFFF;
    if (temp_q < setpoint_q) begin
      heater_q    = 1'b1;
      heat_mark_q = 1'b1;
      cool_mark_q = 1'b0;
    end else if (temp_q > upper) begin
      heater_q    = 1'b0;
      heat_mark_q = 1'b0;
      cool_mark_q = 1'b1;
    end
    r.heater_on = heater_q;
    if (heater_q) n_heat++;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      err_count++;
    end
  endfunction

  // input driver: a beat holds until taken, gaps come from send_idle_pct
  always @(negedge clk) begin
    sample_t s;
    if (rst_n && (!in_if.valid || in_acc_cnt == in_sent_cnt)) begin
      if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct &&
          (!sample_queue[0].drain_first || due_displays.size() == 0)) begin
        s = sample_queue.pop_front();
        in_if.valid         <= 1'b1;
        in_if.knob_sample   <= s.knob;
        in_if.sensor_sample <= s.sens;
        in_sent_cnt = in_sent_cnt + 1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: predict on input beats, compare on result beats
  always @(posedge clk) begin
    display_t exp_d;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        due_displays.push_back(predict_display(in_if.knob_sample, in_if.sensor_sample));
        in_acc_cnt <= in_acc_cnt + 1;
      end
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (due_displays.size() == 0) begin
          $error("result beat with no display expected");
          err_count++;
        end else begin
          exp_d = due_displays.pop_front();
          check_field("heater_on", exp_d.heater_on, out_if.heater_on);
          check_field("show_setpoint", exp_d.show_setpoint, out_if.show_setpoint);
          check_field("off_shown", exp_d.off_shown, out_if.off_shown);
          check_field("shown_value", exp_d.shown_value, out_if.shown_value);
          check_field("seg_first", exp_d.seg_first, out_if.seg_first);
          check_field("seg_second", exp_d.seg_second, out_if.seg_second);
          check_field("seg_third", exp_d.seg_third, out_if.seg_third);
          check_field("seg_fourth", exp_d.seg_fourth, out_if.seg_fourth);
        end
      end
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_CHANGE_BAND: band_q     = val[3:0];
      REG_OFF_BAND:    off_band_q = val[7:0];
      REG_TEMP_OFFSET: offset_q   = val[9:0];
      REG_CONV_GAIN:   gain_q     = val[15:0];
      REG_CONV_BASE:   base_q     = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic write_settings(input int band, input int offb, input int offs,
                                input int gain, input int base);
    reg_write(REG_CHANGE_BAND, band);
    reg_write(REG_OFF_BAND, offb);
    reg_write(REG_TEMP_OFFSET, offs);
    reg_write(REG_CONV_GAIN, gain);
    reg_write(REG_CONV_BASE, base);
    n_settings++;
  endtask

  task automatic queue_sample(input int knob, input int sens, input bit drain);
    sample_queue.push_back('{knob[9:0], sens[9:0], drain});
    items_queued++;
  endtask

  // all queued beats taken and answered, then let the datapath settle
  task automatic wait_drained();
    while (sample_queue.size() != 0 || in_acc_cnt != items_queued ||
           due_displays.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // knob mostly hovers around its last value so the band decides;
  // sensor mostly walks, sometimes jumps
  task automatic queue_random_samples(input int count);
    int sel;
    int knob;
    int step;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 5) begin
        knob = 0;
      end else if (sel < 15) begin
        knob_run = $urandom_range(1, 1023);
        knob = knob_run;
      end else if (sel < 20) begin
        knob_run = ($urandom_range(1)) ? 1023 : $urandom_range(1, 4);
        knob = knob_run;
      end else begin
        step = $urandom_range(0, 2 * band_q + 5);
        knob_run = $urandom_range(1) ? knob_run + step : knob_run - step;
        if (knob_run < 1) knob_run = 1;
        if (knob_run > 1023) knob_run = 1023;
        knob = knob_run;
      end
      sel = $urandom_range(99);
      if (sel < 30) begin
        sens_run = $urandom_range(0, 1023);
      end else if (sel < 38) begin
        sens_run = $urandom_range(1) ? 1023 : 0;
      end else begin
        step = $urandom_range(0, 24);
        sens_run = $urandom_range(1) ? sens_run + step : sens_run - step;
        if (sens_run < 0) sens_run = 0;
        if (sens_run > 1023) sens_run = 1023;
      end
      queue_sample(knob, sens_run, $urandom_range(199) == 0);
    end
  endtask

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.knob_sample = '0;
    in_if.sensor_sample = '0;
    out_if.ready = 1'b0;
    items_queued = 0;
    in_acc_cnt = 0;
    in_sent_cnt = 0;
    err_count = 0;
    n_results = 0;
    n_off = 0;
    n_moved = 0;
    n_heat = 0;
    n_below_zero = 0;
    n_settings = 0;
    knob_run = 512;
    sens_run = 512;
    send_idle_pct = 7;
    recv_stall_pct = 54;
    band_q = RST_CHANGE_BAND;
    off_band_q = RST_OFF_BAND;
    offset_q = RST_TEMP_OFFSET;
    gain_q = RST_CONV_GAIN;
    base_q = RST_CONV_BASE;
    setpoint_q = '0;
    temp_q = '0;
    heat_mark_q = 1'b0;
    cool_mark_q = 1'b0;
    heater_q = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed, on reset register values
    queue_sample(0, 0, 0);        // off right after reset
    queue_sample(1023, 1023, 0);  // full knob, hot sensor -> heater off
    queue_sample(1023, 500, 0);   // same setpoint, previous temperature shown
    queue_sample(1019, 500, 0);   // move equal to band: not taken
    queue_sample(1017, 600, 0);   // band plus one: taken
    queue_sample(0, 1023, 0);     // off while heating, state kept
    queue_sample(1, 0, 0);        // lowest setpoint, conversion below zero
    queue_sample(1, 0, 0);        // below-zero temperature shows 0
    queue_sample(2, 1, 0);
    queue_sample(400, 1023, 0);
    queue_sample(512, 512, 1);    // wait for the pipe to empty first
    queue_sample(1023, 0, 0);
    queue_sample(0, 1023, 0);
    queue_sample(341, 682, 0);
    queue_sample(682, 341, 0);
    wait_drained();

    // directed, readings past 999
    write_settings(1, 10, 0, 30000, int'(RST_CONV_BASE));
    queue_sample(100, 1023, 0);
    queue_sample(100, 1023, 0);
    queue_sample(100, 900, 0);
    queue_sample(100, 800, 0);
    queue_sample(100, 0, 0);
    wait_drained();

    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 7; recv_stall_pct = 54; end
        1: begin send_idle_pct = 54; recv_stall_pct = 7; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      case (ph)
        0: write_settings(int'(RST_CHANGE_BAND), int'(RST_OFF_BAND),
                          int'(RST_TEMP_OFFSET), int'(RST_CONV_GAIN),
                          int'(RST_CONV_BASE));
        1: write_settings(0, 0, 0, 1, 1024);
        2: write_settings(15, 255, 1023, 65535, 65535);
        4: write_settings(7, 128, 512, 65535, 1024);
        default: write_settings($urandom_range(0, 15), $urandom_range(0, 255),
                                $urandom_range(0, 1023), $urandom_range(1, 65535),
                                $urandom_range(1024, 65535));
      endcase
      queue_random_samples(ITEMS_PER_SETTING);
      wait_drained();
    end

    $display("Checked %0d display beats over %0d register settings plus reset values.",
             n_results, n_settings);
    $display("Off beats %0d, setpoint changes %0d, heater-on %0d, below-zero shown %0d.",
             n_off, n_moved, n_heat, n_below_zero);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
